// ----- sv/fwr_pkg.sv -----
package fwr_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int HANDLE_W = 32;
  localparam int RESULT_W = 32;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_PEEK   = 2'd3;

  typedef struct packed {
    logic capture;
    logic push;
    logic pop;
    logic scan_start;
    logic step;
    logic hit;
    logic shift;
    logic shrink;
    logic fetch;
    logic load_head;
    logic respond;
  } fwr_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       multi;
    logic       hit;
    logic       drained;
  } fwr_stat_t;

endpackage

// ----- sv/fifo_with_remove_by_value.sv -----
// Channel  Handshake        Payload
// request  start / busy     cmd, key_value, message_handle
// result   done (strobe)    result_value, head_handle, found, overflow, entry_count, is_empty
//
// A request is taken when start is high and busy is low. Push, peek, remove on
// an empty queue and a pop that leaves the queue empty go straight to the
// response; a pop that leaves entries first reads back the new head, and remove
// uses the single read port of the entry RAM to scan for the key and, if it
// finds it, closes up later entries one per cycle and reads back the new head.
// busy drops as done rises.
// Synchronous reset empties the queue.
// done is high for a single cycle; the result outputs hold until the next result. The receiver cannot stall.
module fifo_with_remove_by_value import fwr_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       cmd,
  input  logic signed [31:0]               key_value,
  input  logic [HANDLE_W-1:0]              message_handle,
  output logic                             done,
  output logic signed [RESULT_W-1:0]       result_value,
  output logic [HANDLE_W-1:0]              head_handle,
  output logic                             found,
  output logic                             overflow,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] entry_count,
  output logic                             is_empty
);

  fwr_ctl_t  ctl;
  fwr_stat_t stat;

  fwr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  fwr_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .cmd            (cmd),
    .key_value      (key_value),
    .message_handle (message_handle),
    .done           (done),
    .result_value   (result_value),
    .head_handle    (head_handle),
    .found          (found),
    .overflow       (overflow),
    .entry_count    (entry_count),
    .is_empty       (is_empty)
  );

endmodule

// ----- sv/fwr_ram.sv -----
module fwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/fwr_ctrl.sv -----
module fwr_ctrl import fwr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  fwr_stat_t stat,
  output fwr_ctl_t  ctl,
  output logic      busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          CMD_PUSH: begin
            ctl.push   = 1'b1;
            state_next = S_RESP;
          end
          CMD_POP: begin
            ctl.pop    = !stat.empty;
            state_next = stat.multi ? S_FETCH : S_RESP;
          end
          CMD_REMOVE: begin
            ctl.scan_start = !stat.empty;
            state_next     = stat.empty ? S_RESP : S_SCAN;
          end
          CMD_PEEK: begin
            state_next = S_RESP;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          ctl.hit    = 1'b1;
          state_next = S_SHIFT;
        end else if (stat.drained) begin
          state_next = S_RESP;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat.drained) begin
          ctl.shrink = 1'b1;
          state_next = stat.multi ? S_FETCH : S_RESP;
        end else begin
          ctl.step  = 1'b1;
          ctl.shift = 1'b1;
        end
      end
      S_FETCH: begin
        ctl.fetch  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        ctl.load_head = 1'b1;
        state_next    = S_RESP;
      end
      S_RESP: begin
        ctl.respond = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/fwr_datapath.sv -----
module fwr_datapath import fwr_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fwr_ctl_t                             ctl,
  output fwr_stat_t                            stat,
  input  logic [1:0]                           cmd,
  input  logic signed [31:0]                   key_value,
  input  logic [HANDLE_W-1:0]                  message_handle,
  output logic                                 done,
  output logic signed [RESULT_W-1:0]           result_value,
  output logic [HANDLE_W-1:0]                  head_handle,
  output logic                                 found,
  output logic                                 overflow,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     entry_count,
  output logic                                 is_empty
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = VALUE_WIDTH + HANDLE_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [CNT_W-1:0] li);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + {1'b0, li};
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  logic [PTR_W-1:0]              head_ptr;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              idx;
  logic [CNT_W-1:0]              cmp_idx;
  logic                          rv;
  logic [1:0]                    cmd_q;
  logic [VALUE_WIDTH-1:0]        key_q;
  logic [HANDLE_W-1:0]           hnd_q;
  logic signed [VALUE_WIDTH-1:0] head_val;
  logic [HANDLE_W-1:0]           head_hnd;
  logic signed [VALUE_WIDTH-1:0] taken;
  logic                          found_q;
  logic                          over_q;

  logic                          wr_en;
  logic [PTR_W-1:0]              wr_addr;
  logic [ENTRY_W-1:0]            wr_data;
  logic [PTR_W-1:0]              rd_addr;
  logic [ENTRY_W-1:0]            rd_data;
  logic [VALUE_WIDTH-1:0]        rd_val;
  logic [HANDLE_W-1:0]           rd_hnd;
  logic                          full;
  logic                          empty;
  logic                          report_head;
  logic signed [VALUE_WIDTH-1:0] res_v;

  assign rd_val = rd_data[ENTRY_W-1:HANDLE_W];
  assign rd_hnd = rd_data[HANDLE_W-1:0];
  assign full   = (count == DEPTH_CNT);
  assign empty  = (count == '0);

  assign stat.cmd     = cmd_q;
  assign stat.empty   = empty;
  assign stat.multi   = (count > CNT_W'(1));
  assign stat.hit     = rv && (rd_val == key_q);
  assign stat.drained = !rv && (idx >= count);

  assign wr_en   = (ctl.push && !full) || (ctl.shift && rv);
  assign wr_addr = ctl.push ? phys(head_ptr, count) : phys(head_ptr, cmp_idx - CNT_W'(1));
  assign wr_data = ctl.push ? {key_q, hnd_q} : rd_data;
  assign rd_addr = ctl.fetch ? phys(head_ptr, '0) : phys(head_ptr, idx);

  fwr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign report_head = (cmd_q == CMD_PUSH) || (cmd_q == CMD_PEEK);

  always_comb begin
    if (report_head) begin
      res_v = empty ? '0 : head_val;
    end else begin
      res_v = taken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      count    <= '0;
      rv       <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= ctl.respond;
      if (ctl.push && !full) begin
        count <= count + CNT_W'(1);
      end
      if (ctl.pop) begin
        head_ptr <= (head_ptr == LAST_PTR) ? '0 : head_ptr + PTR_W'(1);
        count    <= count - CNT_W'(1);
      end
      if (ctl.shrink) begin
        count <= count - CNT_W'(1);
      end
      if (ctl.scan_start || ctl.hit) begin
        rv <= 1'b0;
      end else if (ctl.step) begin
        rv <= (idx < count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= cmd;
      key_q   <= VALUE_WIDTH'($unsigned(key_value));
      hnd_q   <= message_handle;
      taken   <= '0;
      found_q <= 1'b0;
      over_q  <= 1'b0;
    end
    if (ctl.push) begin
      over_q <= full;
      if (empty) begin
        head_val <= key_q;
        head_hnd <= hnd_q;
      end
    end
    if (ctl.pop) begin
      taken   <= head_val;
      found_q <= 1'b1;
    end
    if (ctl.scan_start) begin
      idx <= '0;
    end else if (ctl.hit) begin
      idx     <= cmp_idx + CNT_W'(1);
      taken   <= rd_val;
      found_q <= 1'b1;
    end else if (ctl.step) begin
      cmp_idx <= idx;
      if (idx < count) begin
        idx <= idx + CNT_W'(1);
      end
    end
    if (ctl.load_head) begin
      head_val <= rd_val;
      head_hnd <= rd_hnd;
    end
    if (ctl.respond) begin
      result_value <= RESULT_W'(res_v);
      head_handle  <= empty ? '0 : head_hnd;
      found        <= (cmd_q == CMD_PEEK) ? !empty : found_q;
      overflow     <= over_q;
      entry_count  <= count;
      is_empty     <= empty;
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fwr_pkg::*;

  localparam int DEPTH = DEFAULT_QUEUE_DEPTH;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic [31:0]        hnd;
    logic [6:0]         gap_pct;
    logic               drain;
  } request_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [31:0]        handle;
    logic               found;
    logic               overflow;
    logic [4:0]         count;
    logic               is_empty;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] cmd = CMD_PEEK;
  logic signed [31:0] key_value = '0;
  logic [HANDLE_W-1:0] message_handle = '0;
  logic busy;
  logic done;
  logic signed [RESULT_W-1:0] result_value;
  logic [HANDLE_W-1:0] head_handle;
  logic found;
  logic overflow;
  logic [4:0] entry_count;
  logic is_empty;

  request_t pending_reqs[$];
  reply_t replies_due[$];
  logic signed [31:0] model_vals[DEPTH];
  logic [31:0] model_handles[DEPTH];
  int model_count = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int mismatches = 0;
  logic [31:0] key_pool[8];

  fifo_with_remove_by_value u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .key_value(key_value),
    .message_handle(message_handle),
    .done(done),
    .result_value(result_value),
    .head_handle(head_handle),
    .found(found),
    .overflow(overflow),
    .entry_count(entry_count),
    .is_empty(is_empty)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < model_count; i++) begin
      model_vals[i] = model_vals[i + 1];
      model_handles[i] = model_handles[i + 1];
    end
    model_count--;
  endfunction

  task automatic predict_reply(input logic [1:0] op, input logic signed [31:0] key,
                               input logic [31:0] hnd);
    reply_t r;
    int hit;
    r = '0;
    hit = -1;
    case (op)
      CMD_PUSH: begin
        if (model_count < DEPTH) begin
          model_vals[model_count] = key;
          model_handles[model_count] = hnd;
          model_count++;
        end else begin
          r.overflow = 1'b1;
        end
      end
      CMD_POP: begin
        if (model_count > 0) begin
          r.value = model_vals[0];
          r.found = 1'b1;
          close_gap(0);
        end
      end
      CMD_REMOVE: begin
        for (int i = 0; i < model_count; i++)
          if (hit < 0 && model_vals[i] == key) hit = i;
        if (hit >= 0) begin
          r.value = model_vals[hit];
          r.found = 1'b1;
          close_gap(hit);
        end
      end
      default: begin
        r.found = model_count > 0;
      end
    endcase
    if ((op == CMD_PUSH || op == CMD_PEEK) && model_count > 0) r.value = model_vals[0];
    r.handle = model_count > 0 ? model_handles[0] : '0;
    r.count = 5'(model_count);
    r.is_empty = model_count == 0;
    replies_due.push_back(r);
  endtask

  function automatic void add_req(input logic [1:0] op, input logic [31:0] key,
                                  input logic [31:0] hnd, input int pct, input bit drain);
    request_t q;
    q.op = op;
    q.key = key;
    q.hnd = hnd;
    q.gap_pct = 7'(pct);
    q.drain = drain;
    pending_reqs.push_back(q);
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 70) return key_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  // driver: hold a request until taken, then advance
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd <= CMD_PEEK;
      key_value <= '0;
      message_handle <= '0;
    end else begin
      if (start && !busy) begin
        predict_reply(cmd, key_value, message_handle);
        void'(pending_reqs.pop_front());
        n_accepted++;
      end
      if (start && busy) begin
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].drain && n_accepted != n_checked + int'(done)) &&
                   $urandom_range(99) >= pending_reqs[0].gap_pct) begin
        start <= 1'b1;
        cmd <= pending_reqs[0].op;
        key_value <= pending_reqs[0].key;
        message_handle <= pending_reqs[0].hnd;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst && done) begin
      got.value = result_value;
      got.handle = head_handle;
      got.found = found;
      got.overflow = overflow;
      got.count = entry_count;
      got.is_empty = is_empty;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h handle %h found %b ovf %b count %0d empty %b",
                   got.value, got.handle, got.found, got.overflow, got.count, got.is_empty);
      end else begin
        want = replies_due.pop_front();
        if (got.value !== want.value || got.handle !== want.handle ||
            got.found !== want.found || got.overflow !== want.overflow ||
            got.count !== want.count || got.is_empty !== want.is_empty) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected value %h handle %h found %b ovf %b count %0d empty %b",
                     $realtime, want.value, want.handle, want.found, want.overflow, want.count,
                     want.is_empty);
            $display("  actual: value %h handle %h found %b ovf %b count %0d empty %b",
                     got.value, got.handle, got.found, got.overflow, got.count, got.is_empty);
          end
        end
      end
      n_checked <= n_checked + 1;
    end
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int pct;
    int mode;
    int roll;
    logic [1:0] op;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom();

    add_req(CMD_PEEK, 32'h0, 32'h0, 0, 1'b0);
    add_req(CMD_POP, 32'h0, 32'h0, 0, 1'b0);
    add_req(CMD_REMOVE, 32'h0, 32'hFFFF_FFFF, 0, 1'b0);
    add_req(CMD_PUSH, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
    add_req(CMD_PUSH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
    add_req(CMD_PUSH, 32'h8000_0000, 32'h5A5A_5A5A, 0, 1'b0);
    add_req(CMD_PUSH, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 0, 1'b0);
    add_req(CMD_PUSH, 32'h0000_0000, 32'h0000_0001, 0, 1'b0);
    for (int i = 0; i < 11; i++) add_req(CMD_PUSH, 100 + 3 * i, $urandom(), 0, 1'b0);
    add_req(CMD_PUSH, 32'h1234_5678, 32'hDEAD_0001, 0, 1'b0);
    add_req(CMD_PEEK, $urandom(), $urandom(), 0, 1'b0);
    add_req(CMD_REMOVE, 32'h0000_0000, 32'h0, 0, 1'b0);
    add_req(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 0, 1'b0);
    add_req(CMD_REMOVE, 32'h1357_9BDF, 32'h0, 0, 1'b0);
    add_req(CMD_REMOVE, 100 + 3 * 10, 32'h0, 0, 1'b0);
    add_req(CMD_POP, 32'h0, 32'h0, 0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      pct = ph == 1 ? 47 : (ph == 3 ? 20 : 0);
      for (int i = 4; i < 8; i++) key_pool[i] = $urandom();
      for (int seg = 0; seg < 9; seg++) begin
        mode = $urandom_range(2);
        for (int k = 0; k < 50; k++) begin
          roll = $urandom_range(99);
          if (mode == 0)
            op = roll < 70 ? CMD_PUSH : roll < 80 ? CMD_POP : roll < 92 ? CMD_REMOVE : CMD_PEEK;
          else if (mode == 1)
            op = roll < 15 ? CMD_PUSH : roll < 55 ? CMD_POP : roll < 90 ? CMD_REMOVE : CMD_PEEK;
          else
            op = roll < 35 ? CMD_PUSH : roll < 60 ? CMD_POP : roll < 85 ? CMD_REMOVE : CMD_PEEK;
          add_req(op, pick_key(), $urandom(), pct, k == 0);
        end
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || n_checked != n_accepted) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && replies_due.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
sv/fwr_pkg.sv
sv/fwr_ram.sv
sv/fwr_ctrl.sv
sv/fwr_datapath.sv
sv/fifo_with_remove_by_value.sv
test/tb.sv
